FILE: src/dnp3lf_pkg.sv
// Shared types, constants and the CRC-16/DNP byte step for the link frame deframer.
// No dependencies; every other file of the block refers to it by scoped names.
package dnp3lf_pkg;

  localparam int MAX_FRAME_BYTES  = 292;
  localparam int USER_CAPACITY    = 250;
  localparam int BLOCK_DATA_BYTES = 16;

  localparam int HDR_BYTES   = 10;
  localparam int STORE_DEPTH = 18;
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int POS_W       = 9;
  localparam int COUNT_W     = 9;

  localparam logic [15:0] CRC_POLY = 16'hA6BC;

  localparam logic        RST_CRC_EN    = 1'b1;
  localparam logic [7:0]  RST_MIN_LEN   = 8'd6;
  localparam logic [15:0] RST_RSVD_LOW  = 16'hFFF0;
  localparam logic [15:0] RST_RSVD_HIGH = 16'hFFFB;

  localparam logic [1:0] CFG_CRC_EN    = 2'd0;
  localparam logic [1:0] CFG_MIN_LEN   = 2'd1;
  localparam logic [1:0] CFG_RSVD_LOW  = 2'd2;
  localparam logic [1:0] CFG_RSVD_HIGH = 2'd3;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_LONG      = 3'd2,
    VERDICT_LEN_FIELD = 3'd3,
    VERDICT_RSVD_ADDR = 3'd4,
    VERDICT_HDR_CRC   = 3'd5,
    VERDICT_BLOCK_CRC = 3'd6
  } verdict_t;

  typedef struct packed {
    logic                is_verdict;
    logic                bank;
    logic [FILL_W-1:0]   len;
    logic [COUNT_W-1:0]  base;
    verdict_t            verdict;
  } cmd_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    cmd_t cmd_a;
    cmd_t cmd_b;
  } q_push_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  function automatic logic [15:0] crc_feed(logic [15:0] acc, logic [7:0] b);
    logic [15:0] t;
    t = {8'h00, acc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
    end
    return (acc >> 8) ^ t;
  endfunction

endpackage

FILE: src/dnp3lf_ifs.sv
// Valid/ready channel interfaces for frame bytes in and result items out.
// Depends on dnp3lf_pkg for field widths.
interface dnp3lf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source(output valid, frame_byte, frame_end, input ready);
  modport sink(input valid, frame_byte, frame_end, output ready);
endinterface

interface dnp3lf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           item_kind;
  logic [7:0]                     user_byte;
  logic [2:0]                     verdict;
  logic [dnp3lf_pkg::COUNT_W-1:0] user_count;
  logic                           run_last;
  modport source(output valid, item_kind, user_byte, verdict, user_count, run_last,
                 input ready);
  modport sink(input valid, item_kind, user_byte, verdict, user_count, run_last,
               output ready);
endinterface

FILE: src/dnp3_link_frame_crc_deframer_top.sv
// Top level of the link frame deframer: front end, command queue and back end.
// Depends on dnp3lf_pkg, dnp3lf_ifs, dnp3lf_front, dnp3lf_cmdq and dnp3lf_back.
//
// frame_in carries one raw link frame byte per transfer, frame_end on the last.
// item_out carries verified user data bytes and one verdict item per frame.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while the block is idle; the block itself does not enforce this. The front
// end takes one byte per cycle while frame_in.ready is high; the CRC step is a
// bitwise loop. A full block is checked when the byte after it arrives; its data
// bytes leave one per cycle while item_out is ready, from a two-bank block memory
// through the output register; a verdict follows the last byte, or the leftover block.
// Sustained input rate is one byte per cycle; frame_in.ready drops only while
// the command queue is near full or the bank to be written is still draining.
// The output register lets the back end hold a result while the front keeps
// taking bytes; a stalled item_out fills the queue and then stops frame_in.
// Reset (rst, synchronous) clears frame state, the queue and the output, and
// restores the configuration registers to their defaults; no clearing pass.
module dnp3_link_frame_crc_deframer_top #(
  parameter int MaxFrameBytes  = dnp3lf_pkg::MAX_FRAME_BYTES,
  parameter int UserCapacity   = dnp3lf_pkg::USER_CAPACITY,
  parameter int BlockDataBytes = dnp3lf_pkg::BLOCK_DATA_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  dnp3lf_in_if.sink   frame_in,
  dnp3lf_out_if.source item_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dnp3lf_pkg::q_push_t q_push;
  dnp3lf_pkg::mem_wr_t mem_wr;
  dnp3lf_pkg::cmd_t    head;
  logic                head_valid;
  logic                room;
  logic                pop;
  logic [1:0]          bank_release;

  dnp3lf_front #(
    .MaxFrameBytes (MaxFrameBytes),
    .UserCapacity  (UserCapacity),
    .BlockDataBytes(BlockDataBytes)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_in    (frame_in),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_room      (room),
    .bank_release(bank_release),
    .q_push      (q_push),
    .mem_wr      (mem_wr)
  );

  dnp3lf_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .q_push    (q_push),
    .pop       (pop),
    .room      (room),
    .head_valid(head_valid),
    .head      (head)
  );

  dnp3lf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mem_wr      (mem_wr),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .bank_release(bank_release),
    .item_out    (item_out)
  );

endmodule

FILE: src/dnp3lf_front.sv
// Front end: accepts frame bytes, runs the CRC, checks header and blocks, writes
// block bytes to the bank memory and queues emit and verdict commands. Uses dnp3lf_pkg.
module dnp3lf_front #(
  parameter int MaxFrameBytes  = dnp3lf_pkg::MAX_FRAME_BYTES,
  parameter int UserCapacity   = dnp3lf_pkg::USER_CAPACITY,
  parameter int BlockDataBytes = dnp3lf_pkg::BLOCK_DATA_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  dnp3lf_in_if.sink           frame_in,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                q_room,
  input  logic [1:0]          bank_release,
  output dnp3lf_pkg::q_push_t q_push,
  output dnp3lf_pkg::mem_wr_t mem_wr
);

  localparam int FW = dnp3lf_pkg::FILL_W;
  localparam int PW = dnp3lf_pkg::POS_W;
  localparam int CW = dnp3lf_pkg::COUNT_W;
  localparam logic [FW-1:0] FullFill = FW'(BlockDataBytes + 2);
  localparam logic [PW-1:0] HdrLast  = PW'(dnp3lf_pkg::HDR_BYTES - 1);
  localparam logic [PW-1:0] HdrBytes = PW'(dnp3lf_pkg::HDR_BYTES);
  localparam logic [PW-1:0] PosMax   = {PW{1'b1}};

  logic        crc_en;
  logic [7:0]  min_len;
  logic [15:0] rsvd_low;
  logic [15:0] rsvd_high;

  logic [PW-1:0]  pos;
  logic [15:0]    acc;
  logic [7:0]     last1;
  logic [7:0]     last2;
  logic [FW-1:0]  fill;
  logic [7:0]     len_field;
  logic [15:0]    dst;
  logic [15:0]    src;
  dnp3lf_pkg::verdict_t err;
  logic [CW-1:0]  total;
  logic           cap_stop;
  logic           wbank;
  logic [1:0]     busy;

  logic           accept;
  logic           data_phase;
  logic           flush;
  logic [15:0]    crc_fed;
  logic           full_ok;
  logic           tail_ok;
  logic [7:0]     b;
  logic           fend;

  dnp3lf_pkg::verdict_t err_next;
  dnp3lf_pkg::verdict_t frame_verdict;
  logic           cap_next;
  logic [CW-1:0]  total_next;
  logic           commit_full;
  logic           commit_tail;
  logic           bank_wr;
  logic           wbank_next;
  logic [FW-1:0]  fill_s;
  logic [FW-1:0]  f;
  logic [15:0]    acc_next;
  logic [1:0]     busy_set;

  function automatic logic reserved(logic [15:0] a, logic [15:0] lo, logic [15:0] hi);
    return (a >= lo) && (a <= hi);
  endfunction

  assign b          = frame_in.frame_byte;
  assign fend       = frame_in.frame_end;
  assign data_phase = pos >= HdrBytes;
  assign flush      = data_phase && (fill == FullFill);
  assign frame_in.ready = q_room && !(data_phase && busy[wbank]) && !(flush && busy[~wbank]);
  assign accept     = frame_in.valid && frame_in.ready;

  assign crc_fed = dnp3lf_pkg::crc_feed(acc, last2);
  assign full_ok = !crc_en || (last2 == ~acc[7:0] && last1 == ~acc[15:8]);
  assign tail_ok = !crc_en || (last1 == ~crc_fed[7:0] && b == ~crc_fed[15:8]);

  always_comb begin
    err_next    = err;
    cap_next    = cap_stop;
    total_next  = total;
    commit_full = 1'b0;
    commit_tail = 1'b0;
    if ({1'b0, pos} >= (PW + 1)'(MaxFrameBytes)) begin
      err_next = dnp3lf_pkg::VERDICT_LONG;
    end
    if (pos == HdrLast && err_next == dnp3lf_pkg::VERDICT_OK) begin
      if (len_field < min_len) begin
        err_next = dnp3lf_pkg::VERDICT_LEN_FIELD;
      end else if (reserved(src, rsvd_low, rsvd_high) || reserved(dst, rsvd_low, rsvd_high)) begin
        err_next = dnp3lf_pkg::VERDICT_RSVD_ADDR;
      end else if (!tail_ok) begin
        err_next = dnp3lf_pkg::VERDICT_HDR_CRC;
      end
    end
    if (flush && err_next == dnp3lf_pkg::VERDICT_OK && !cap_next) begin
      if ((CW + 1)'(total) + (CW + 1)'(BlockDataBytes) < (CW + 1)'(UserCapacity)) begin
        if (!full_ok) begin
          err_next = dnp3lf_pkg::VERDICT_BLOCK_CRC;
        end else begin
          commit_full = 1'b1;
          total_next  = total + CW'(BlockDataBytes);
        end
      end else begin
        cap_next = 1'b1;
      end
    end
    bank_wr = commit_full ? ~wbank : wbank;
    fill_s  = flush ? '0 : fill;
    if (flush) begin
      acc_next = '0;
    end else if (fill >= FW'(2)) begin
      acc_next = crc_fed;
    end else begin
      acc_next = acc;
    end
    f = fill_s + FW'(1);
    if (fend && data_phase && f > FW'(2) && err_next == dnp3lf_pkg::VERDICT_OK && !cap_next &&
        (CW + 1)'(total_next) + (CW + 1)'(f) < (CW + 1)'(UserCapacity)) begin
      if (!tail_ok) begin
        err_next = dnp3lf_pkg::VERDICT_BLOCK_CRC;
      end else begin
        commit_tail = 1'b1;
        total_next  = total_next + CW'(f - FW'(2));
      end
    end
    wbank_next    = bank_wr ^ commit_tail;
    frame_verdict = (pos < HdrBytes) ? dnp3lf_pkg::VERDICT_SHORT : err_next;

    q_push.push_a = accept && (commit_full || commit_tail || fend);
    q_push.push_b = accept && fend && (commit_full || commit_tail);
    q_push.cmd_b.is_verdict = 1'b1;
    q_push.cmd_b.bank       = 1'b0;
    q_push.cmd_b.len        = '0;
    q_push.cmd_b.base       = total_next;
    q_push.cmd_b.verdict    = frame_verdict;
    if (commit_full || commit_tail) begin
      q_push.cmd_a.is_verdict = 1'b0;
      q_push.cmd_a.bank       = commit_full ? wbank : bank_wr;
      q_push.cmd_a.len        = commit_full ? FW'(BlockDataBytes) : f - FW'(2);
      q_push.cmd_a.base       = total;
      q_push.cmd_a.verdict    = dnp3lf_pkg::VERDICT_OK;
    end else begin
      q_push.cmd_a = q_push.cmd_b;
    end

    mem_wr.en   = accept && data_phase;
    mem_wr.bank = bank_wr;
    mem_wr.addr = fill_s[dnp3lf_pkg::IDX_W-1:0];
    mem_wr.data = b;

    busy_set = '0;
    if (accept && commit_full) begin
      busy_set[wbank] = 1'b1;
    end
    if (accept && commit_tail) begin
      busy_set[bank_wr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_en    <= dnp3lf_pkg::RST_CRC_EN;
      min_len   <= dnp3lf_pkg::RST_MIN_LEN;
      rsvd_low  <= dnp3lf_pkg::RST_RSVD_LOW;
      rsvd_high <= dnp3lf_pkg::RST_RSVD_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        dnp3lf_pkg::CFG_CRC_EN:    crc_en    <= cfg_data[0];
        dnp3lf_pkg::CFG_MIN_LEN:   min_len   <= cfg_data[7:0];
        dnp3lf_pkg::CFG_RSVD_LOW:  rsvd_low  <= cfg_data;
        dnp3lf_pkg::CFG_RSVD_HIGH: rsvd_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      acc      <= '0;
      fill     <= '0;
      err      <= dnp3lf_pkg::VERDICT_OK;
      total    <= '0;
      cap_stop <= 1'b0;
      wbank    <= 1'b0;
      busy     <= '0;
    end else begin
      busy <= (busy & ~bank_release) | busy_set;
      if (accept) begin
        wbank <= wbank_next;
        last2 <= last1;
        last1 <= b;
        if (fend) begin
          pos      <= '0;
          acc      <= '0;
          fill     <= '0;
          err      <= dnp3lf_pkg::VERDICT_OK;
          total    <= '0;
          cap_stop <= 1'b0;
        end else begin
          pos      <= (pos == PosMax) ? pos : pos + PW'(1);
          err      <= err_next;
          total    <= total_next;
          cap_stop <= cap_next;
          if (pos == HdrLast) begin
            acc  <= '0;
            fill <= '0;
          end else begin
            acc  <= acc_next;
            fill <= f;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos)
        PW'(2):  len_field  <= b;
        PW'(4):  dst[7:0]   <= b;
        PW'(5):  dst[15:8]  <= b;
        PW'(6):  src[7:0]   <= b;
        PW'(7):  src[15:8]  <= b;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/dnp3lf_cmdq.sv
// Four-entry command queue between front and back; takes up to two commands a cycle.
// Uses dnp3lf_pkg for the command type.
module dnp3lf_cmdq (
  input  logic                clk,
  input  logic                rst,
  input  dnp3lf_pkg::q_push_t q_push,
  input  logic                pop,
  output logic                room,
  output logic                head_valid,
  output dnp3lf_pkg::cmd_t    head
);

  dnp3lf_pkg::cmd_t slots [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic [2:0] n_push;

  assign n_push     = 3'(q_push.push_a) + 3'(q_push.push_b);
  assign room       = count <= 3'd2;
  assign head_valid = count != 3'd0;
  assign head       = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_push[1:0];
      rp    <= rp + 2'(pop);
      count <= count + n_push - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push_a) begin
      slots[wp] <= q_push.cmd_a;
    end
    if (q_push.push_b) begin
      slots[wp + 2'd1] <= q_push.cmd_b;
    end
  end

endmodule

FILE: src/dnp3lf_back.sv
// Back end: holds the two block banks, drains queued blocks byte by byte and
// sends verdict items into the output register. Uses dnp3lf_pkg and dnp3lf_out_if.
module dnp3lf_back (
  input  logic                clk,
  input  logic                rst,
  input  dnp3lf_pkg::mem_wr_t mem_wr,
  input  logic                head_valid,
  input  dnp3lf_pkg::cmd_t    head,
  output logic                pop,
  output logic [1:0]          bank_release,
  dnp3lf_out_if.source        item_out
);

  localparam int FW = dnp3lf_pkg::FILL_W;
  localparam int IW = dnp3lf_pkg::IDX_W;
  localparam int CW = dnp3lf_pkg::COUNT_W;

  logic [7:0] banks [2][dnp3lf_pkg::STORE_DEPTH];

  logic          active;
  logic          bank;
  logic [FW-1:0] idx;
  logic [FW-1:0] len;
  logic [CW-1:0] base;
  logic          out_valid;

  logic          load;
  logic          rd_bank;
  logic [IW-1:0] rd_idx;

  assign load           = !out_valid || item_out.ready;
  assign pop            = load && !active && head_valid;
  assign item_out.valid = out_valid;
  assign rd_bank        = active ? bank : head.bank;
  assign rd_idx         = active ? idx[IW-1:0] : '0;

  always_comb begin
    bank_release = '0;
    if (load && active && idx == len - FW'(1)) begin
      bank_release[bank] = 1'b1;
    end
    if (pop && !head.is_verdict && head.len == FW'(1)) begin
      bank_release[head.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      banks[mem_wr.bank][mem_wr.addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= active || head_valid;
      if (active) begin
        idx <= idx + FW'(1);
        if (idx == len - FW'(1)) begin
          active <= 1'b0;
        end
      end else if (head_valid && !head.is_verdict) begin
        bank   <= head.bank;
        len    <= head.len;
        base   <= head.base;
        idx    <= FW'(1);
        active <= head.len != FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (!active && head.is_verdict) begin
        item_out.item_kind  <= dnp3lf_pkg::KIND_VERDICT;
        item_out.user_byte  <= '0;
        item_out.verdict    <= head.verdict;
        item_out.user_count <= head.base;
        item_out.run_last   <= 1'b1;
      end else begin
        item_out.item_kind  <= dnp3lf_pkg::KIND_DATA;
        item_out.user_byte  <= banks[rd_bank][rd_idx];
        item_out.verdict    <= dnp3lf_pkg::VERDICT_OK;
        item_out.user_count <= active ? base + CW'(idx) + CW'(1) : head.base + CW'(1);
        item_out.run_last   <= 1'b0;
      end
    end
  end

endmodule
